// File: sv/line_editor_field_tokenizer_defines.svh
// assertion macros used by the checker file
`ifndef LINE_EDITOR_FIELD_TOKENIZER_DEFINES_SVH
`define LINE_EDITOR_FIELD_TOKENIZER_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define LFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define LFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lft_pkg.sv
// shared constants, types and character classes of the line editor
package lft_pkg;

  // line and field limits
  localparam int LINE_CHARS  = 80;
  localparam int FIELD_LIMIT = 5;
  localparam int CNT_W       = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W      = $clog2(LINE_CHARS);
  localparam int FOUND_W     = $clog2(FIELD_LIMIT + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_DEL     = 8'd127;

  localparam logic [31:0] VALUE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_BACKSPACE = 2'd0,
    OP_ENTER     = 2'd1,
    OP_STORE     = 2'd2
  } op_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  echo_byte;
    logic [3:0]  field_index;
    logic [7:0]  field_start;
    logic [7:0]  field_length;
    logic        field_numeric;
    logic [31:0] field_value;
    logic [4:0]  field_count;
    logic        too_many_fields;
    logic        last;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

// File: sv/lft_front.sv
// front end: accepts bytes and classifies them into queue commands
module lft_front import lft_pkg::*; (
  input  logic       in_valid,
  input  logic [7:0] in_char_in,
  output logic       in_stall,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic keep;

  // classify the byte; control codes other than backspace and enter are dropped
  always_comb begin
    keep         = 1'b0;
    push_cmd.op  = OP_STORE;
    push_cmd.ch  = in_char_in;
    if (in_char_in inside {CH_BS, CH_DEL}) begin
      keep        = 1'b1;
      push_cmd.op = OP_BACKSPACE;
    end else if (in_char_in == CH_CR) begin
      keep        = 1'b1;
      push_cmd.op = OP_ENTER;
    end else if (in_char_in >= CH_SPACE) begin
      keep        = 1'b1;
      push_cmd.op = OP_STORE;
    end
  end

  // hold requests off while the queue is full
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

endmodule

// File: sv/lft_queue.sv
// short command queue between front and back
module lft_queue import lft_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/lft_back.sv
// back end: line store, echo, field walk and result register
module lft_back import lft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_empty,
  input  cmd_t    q_head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ECHO    = 5'b00010,
    ST_READ    = 5'b00100,
    ST_SCAN    = 5'b01000,
    ST_SUMMARY = 5'b10000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [7:0]  line_mem [LINE_CHARS];
  logic [7:0]  rd_data_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   start_r, start_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic               in_field_r, in_field_nxt;
  logic               numeric_r, numeric_nxt;
  logic               over_r, over_nxt;
  logic               walk_after_r, walk_after_nxt;
  logic [7:0]         echo_r, echo_nxt;
  logic [31:0]        val_r, val_nxt;

  logic        out_valid_r;
  result_t     res_r, res_nxt;
  logic        load;
  logic        slot_free;
  logic        mem_we;

  logic        at_end;
  logic        c_letter, c_digit, c_field;
  logic [31:0] val_base;
  logic        numeric_base;
  logic [35:0] val_wide;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // character class of the byte under the walk
  assign at_end   = (pos_r == count_r);
  assign c_letter = is_letter(rd_data_r);
  assign c_digit  = is_digit(rd_data_r);
  assign c_field  = !at_end && (c_letter || c_digit);

  // decimal accumulate with saturation
  assign val_base     = in_field_r ? val_r : '0;
  assign numeric_base = in_field_r ? numeric_r : 1'b1;
  assign val_wide     = (36'(val_base) << 3) + (36'(val_base) << 1)
                        + 36'(4'(rd_data_r - CH_ZERO));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    found_nxt      = found_r;
    in_field_nxt   = in_field_r;
    numeric_nxt    = numeric_r;
    over_nxt       = over_r;
    walk_after_nxt = walk_after_r;
    echo_nxt       = echo_r;
    val_nxt        = val_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    load           = 1'b0;
    res_nxt        = '0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (q_head.op)
            OP_BACKSPACE: begin
              if (count_r != '0) begin
                count_nxt      = count_r - 1'b1;
                echo_nxt       = q_head.ch;
                walk_after_nxt = 1'b0;
                state_nxt      = ST_ECHO;
              end
            end
            OP_ENTER: begin
              echo_nxt       = CH_LF;
              walk_after_nxt = 1'b1;
              state_nxt      = ST_ECHO;
            end
            OP_STORE: begin
              mem_we         = 1'b1;
              count_nxt      = count_r + 1'b1;
              echo_nxt       = q_head.ch;
              walk_after_nxt = (count_r == CNT_W'(LINE_CHARS - 1));
              state_nxt      = ST_ECHO;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          load              = 1'b1;
          res_nxt.kind      = KIND_ECHO;
          res_nxt.echo_byte = echo_r;
          res_nxt.last      = !walk_after_r;
          pos_nxt           = '0;
          found_nxt         = '0;
          in_field_nxt      = 1'b0;
          over_nxt          = 1'b0;
          state_nxt         = walk_after_r ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (c_field) begin
          // extend or open a field
          in_field_nxt = 1'b1;
          if (!in_field_r) begin
            start_nxt = pos_r;
          end
          numeric_nxt = numeric_base && c_digit;
          if (c_digit) begin
            val_nxt = (val_wide > 36'(VALUE_MAX)) ? VALUE_MAX : val_wide[31:0];
          end else begin
            val_nxt = val_base;
          end
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_READ;
        end else if (in_field_r) begin
          // a field closes here
          if (found_r == FOUND_W'(FIELD_LIMIT)) begin
            over_nxt  = 1'b1;
            state_nxt = ST_SUMMARY;
          end else if (slot_free) begin
            load                  = 1'b1;
            res_nxt.kind          = KIND_FIELD;
            res_nxt.field_index   = 4'(found_r);
            res_nxt.field_start   = 8'(start_r);
            res_nxt.field_length  = 8'(pos_r - start_r);
            res_nxt.field_numeric = numeric_r;
            res_nxt.field_value   = numeric_r ? val_r : '0;
            found_nxt             = found_r + 1'b1;
            in_field_nxt          = 1'b0;
            if (at_end) begin
              state_nxt = ST_SUMMARY;
            end else begin
              pos_nxt   = pos_r + 1'b1;
              state_nxt = ST_READ;
            end
          end
        end else if (at_end) begin
          state_nxt = ST_SUMMARY;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_SUMMARY: begin
        if (slot_free) begin
          load                    = 1'b1;
          res_nxt.kind            = KIND_SUMMARY;
          res_nxt.field_count     = 5'(found_r);
          res_nxt.too_many_fields = over_r;
          res_nxt.last            = 1'b1;
          count_nxt               = '0;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      found_r     <= '0;
      in_field_r  <= 1'b0;
      over_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pos_r      <= pos_nxt;
      found_r    <= found_nxt;
      in_field_r <= in_field_nxt;
      over_r     <= over_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    numeric_r    <= numeric_nxt;
    walk_after_r <= walk_after_nxt;
    echo_r       <= echo_nxt;
    val_r        <= val_nxt;
    if (load) begin
      res_r <= res_nxt;
    end
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[count_r[ADDR_W-1:0]] <= q_head.ch;
    end
    if ((state_r == ST_READ) && !at_end) begin
      rd_data_r <= line_mem[pos_r[ADDR_W-1:0]];
    end
  end

endmodule

// File: sv/line_editor_field_tokenizer.sv
// top level of the line editor with field tokenizer
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   in_char_in
//   out      result     out_valid / out_stall out_kind .. out_last
//
// a byte that only echoes passes through the idle and echo states of the back
// end after it leaves the queue; a line end then walks the stored characters
// through the single read port of the line store, alternating the read and
// scan states, and ends with the summary; a field record shares the cycle of
// the delimiter that closes it, and a line with too many fields stops at the
// delimiter past the limit. synchronous active-low reset clears the queue,
// the character count and the output valid flag; the line store needs no
// clearing. a stalled output holds the back end, and the two-entry queue
// keeps taking bytes until it fills.
module line_editor_field_tokenizer import lft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_char_in,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_echo_byte,
  output logic [3:0]  out_field_index,
  output logic [7:0]  out_field_start,
  output logic [7:0]  out_field_length,
  output logic        out_field_numeric,
  output logic [31:0] out_field_value,
  output logic [4:0]  out_field_count,
  output logic        out_too_many_fields,
  output logic        out_last
);

  logic    q_full, q_empty, push, pop;
  cmd_t    push_cmd, q_head;
  result_t res;

  // classify incoming bytes
  lft_front u_front (
    .in_valid   (in_valid),
    .in_char_in (in_char_in),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouple front from back
  lft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // carry out commands and produce results
  lft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // unpack the result register
  assign out_kind            = res.kind;
  assign out_echo_byte       = res.echo_byte;
  assign out_field_index     = res.field_index;
  assign out_field_start     = res.field_start;
  assign out_field_length    = res.field_length;
  assign out_field_numeric   = res.field_numeric;
  assign out_field_value     = res.field_value;
  assign out_field_count     = res.field_count;
  assign out_too_many_fields = res.too_many_fields;
  assign out_last            = res.last;

endmodule

// File: sv/lft_checker.sv
// port-level checks for the line editor, bound to the top level
`include "line_editor_field_tokenizer_defines.svh"

module lft_checker import lft_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_echo_byte,
  input logic [3:0]  out_field_index,
  input logic [7:0]  out_field_start,
  input logic [7:0]  out_field_length,
  input logic        out_field_numeric,
  input logic [31:0] out_field_value,
  input logic [4:0]  out_field_count,
  input logic        out_too_many_fields,
  input logic        out_last
);

  logic [69:0] out_bus;
  logic        out_wait, is_summary, is_field, over_seen, limit_hit;

  // whole result payload and result classes
  assign out_bus    = {out_kind, out_echo_byte, out_field_index, out_field_start,
                       out_field_length, out_field_numeric, out_field_value,
                       out_field_count, out_too_many_fields, out_last};
  assign out_wait   = out_valid && out_stall;
  assign is_summary = out_valid && (out_kind == KIND_SUMMARY);
  assign is_field   = out_valid && (out_kind == KIND_FIELD);
  assign over_seen  = out_valid && out_too_many_fields;
  assign limit_hit  = (out_field_count == 5'(FIELD_LIMIT));

  // a stalled result holds
  `LFT_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_bus), "stalled result changed")

  // the summary closes every line walk
  `LFT_ASSERT_NOW(a_summary_last, is_summary, out_last, "summary not marked last")

  // a field record is always followed by more results of the same byte
  `LFT_ASSERT_NOW(a_field_not_last, is_field, !out_last, "field record marked last")

  // overflow only once the record limit is reached
  `LFT_ASSERT_NOW(a_overflow_count, over_seen, is_summary && limit_hit, "overflow below limit")

endmodule

bind line_editor_field_tokenizer lft_checker u_checker (.*);
